@@ rtl/core/iisrs_pkg.sv @@
// shared types and codes for the interval index set rank/select block
package iisrs_pkg;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_INSERT   = 3'd1;
    localparam logic [2:0] CMD_SELECT   = 3'd2;
    localparam logic [2:0] CMD_RANK     = 3'd3;
    localparam logic [2:0] CMD_CONTAINS = 3'd4;
    localparam logic [2:0] CMD_LOCAL    = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_SELECT,
        OP_RANK,
        OP_CONTAINS,
        OP_LOCAL,
        OP_BAD
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH,
        S_SCMP,
        S_POST,
        S_SELD,
        S_LEFT,
        S_RIGHT,
        S_ACT,
        S_DN_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_RB_RD,
        S_RB_WR,
        S_DONE
    } state_t;

endpackage

@@ rtl/core/iisrs_ram.sv @@
// generic single write port ram with registered read
module iisrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/iisrs_front.sv @@
// front end: request queue that decodes the command and trims the key
module iisrs_front
    import iisrs_pkg::*;
#(
    parameter int KW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    command,
    input  logic [31:0]   key,
    output logic          q_valid,
    input  logic          q_take,
    output op_t           q_op,
    output logic [KW-1:0] q_key
);

    op_t           op_mem [2];
    logic [KW-1:0] key_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    op_t           dec_op;
    logic [63:0]   key_wide;
    logic          do_push, do_pop;

    always_comb
    begin
        case (command)
            CMD_CLEAR:    dec_op = OP_CLEAR;
            CMD_INSERT:   dec_op = OP_INSERT;
            CMD_SELECT:   dec_op = OP_SELECT;
            CMD_RANK:     dec_op = OP_RANK;
            CMD_CONTAINS: dec_op = OP_CONTAINS;
            CMD_LOCAL:    dec_op = OP_LOCAL;
            default:      dec_op = OP_BAD;
        endcase
    end

    assign key_wide = 64'(key);
    assign full     = (fill_reg == 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_op     = op_mem[rd_ptr_reg];
    assign q_key    = key_mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            op_mem[wr_ptr_reg]  <= dec_op;
            key_mem[wr_ptr_reg] <= key_wide[KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ rtl/core/iisrs_back.sv @@
// back end: run table engine with binary search, shifting, offset rebuild
module iisrs_back
    import iisrs_pkg::*;
#(
    parameter int MAX_RUNS = 64,
    parameter int KW       = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_take,
    input  op_t           q_op,
    input  logic [KW-1:0] q_key,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   value,
    output logic [1:0]    status
);

    localparam int AW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [KW-1:0] key_reg, key_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] count_reg, count_next;
    logic [KW:0]   mcount_reg, mcount_next;
    logic [KW:0]   acc_reg, acc_next;
    logic          left_reg, left_next;
    logic [KW:0]   res_value_reg, res_value_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_value_reg, out_value_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic [AW-1:0] raddr;
    logic          we_start, we_last, we_off;
    logic [AW-1:0] waddr;
    logic [KW-1:0] start_wd, last_wd;
    logic [KW:0]   off_wd;
    logic [KW-1:0] start_rd, last_rd;
    logic [KW:0]   off_rd;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] lo_m1;
    logic [63:0]   res_wide;
    logic          right;

    iisrs_ram #(.WIDTH(KW), .DEPTH(MAX_RUNS)) u_start (
        .clk(clk), .we(we_start), .waddr(waddr), .wdata(start_wd),
        .raddr(raddr), .rdata(start_rd)
    );

    iisrs_ram #(.WIDTH(KW), .DEPTH(MAX_RUNS)) u_last (
        .clk(clk), .we(we_last), .waddr(waddr), .wdata(last_wd),
        .raddr(raddr), .rdata(last_rd)
    );

    iisrs_ram #(.WIDTH(KW + 1), .DEPTH(MAX_RUNS)) u_off (
        .clk(clk), .we(we_off), .waddr(waddr), .wdata(off_wd),
        .raddr(raddr), .rdata(off_rd)
    );

    assign mid_sum  = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
    assign lo_m1    = lo_reg - CW'(1);
    assign res_wide = 64'(res_value_reg);
    assign right    = ({1'b0, start_rd} == ({1'b0, key_reg} + (KW+1)'(1)));
    assign empty    = !out_valid_reg;
    assign value    = out_value_reg;
    assign status   = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        j_next          = j_reg;
        count_next      = count_reg;
        mcount_next     = mcount_reg;
        acc_next        = acc_reg;
        left_next       = left_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_take          = 1'b0;
        raddr           = '0;
        we_start        = 1'b0;
        we_last         = 1'b0;
        we_off          = 1'b0;
        waddr           = '0;
        start_wd        = key_reg;
        last_wd         = key_reg;
        off_wd          = acc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take          = 1'b1;
                    op_next         = q_op;
                    key_next        = q_key;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    res_value_next  = '0;
                    res_status_next = ST_MISS;
                    state_next      = S_DONE;
                    case (q_op)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            mcount_next     = '0;
                            res_status_next = ST_OK;
                        end
                        OP_LOCAL:
                        begin
                            if ({1'b0, q_key} < mcount_reg)
                            begin
                                res_status_next = ST_OK;
                            end
                        end
                        OP_SELECT:
                        begin
                            if ({1'b0, q_key} < mcount_reg)
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        OP_INSERT, OP_RANK, OP_CONTAINS:
                        begin
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[CW-1:0];
                    raddr      = mid_sum[AW-1:0];
                    state_next = S_SCMP;
                end
                else
                begin
                    state_next = S_POST;
                end
            end

            S_SCMP:
            begin
                if ((op_reg == OP_SELECT) ? (off_rd <= {1'b0, key_reg})
                                          : (start_rd <= key_reg))
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end

            S_POST:
            begin
                if (op_reg == OP_SELECT)
                begin
                    raddr      = lo_m1[AW-1:0];
                    state_next = S_SELD;
                end
                else if (lo_reg != '0)
                begin
                    raddr      = lo_m1[AW-1:0];
                    state_next = S_LEFT;
                end
                else if (op_reg != OP_INSERT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    left_next = 1'b0;
                    if (lo_reg < count_reg)
                    begin
                        raddr      = lo_reg[AW-1:0];
                        state_next = S_RIGHT;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
            end

            S_SELD:
            begin
                res_value_next  = {1'b0, start_rd} + ({1'b0, key_reg} - off_rd);
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_LEFT:
            begin
                if (key_reg <= last_rd)
                begin
                    res_status_next = ST_OK;
                    if (op_reg == OP_RANK)
                    begin
                        res_value_next = off_rd + {1'b0, key_reg - start_rd};
                    end
                    state_next = S_DONE;
                end
                else if (op_reg != OP_INSERT)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    left_next = (({1'b0, last_rd} + (KW+1)'(1)) == {1'b0, key_reg});
                    if (lo_reg < count_reg)
                    begin
                        raddr      = lo_reg[AW-1:0];
                        state_next = S_RIGHT;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
            end

            S_RIGHT:
            begin
                if (right && left_reg)
                begin
                    we_last    = 1'b1;
                    waddr      = lo_m1[AW-1:0];
                    last_wd    = last_rd;
                    j_next     = lo_reg;
                    state_next = S_DN_RD;
                end
                else if (right)
                begin
                    we_start   = 1'b1;
                    waddr      = lo_reg[AW-1:0];
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_RB_RD;
                end
                else
                begin
                    state_next = S_ACT;
                end
            end

            S_ACT:
            begin
                if (left_reg)
                begin
                    we_last    = 1'b1;
                    waddr      = lo_m1[AW-1:0];
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_RB_RD;
                end
                else if (count_reg == CW'(MAX_RUNS))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = S_UP_RD;
                end
            end

            S_DN_RD:
            begin
                if ((j_reg + CW'(1)) < count_reg)
                begin
                    raddr      = AW'(j_reg + CW'(1));
                    state_next = S_DN_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_RB_RD;
                end
            end

            S_DN_WR:
            begin
                we_start   = 1'b1;
                we_last    = 1'b1;
                waddr      = j_reg[AW-1:0];
                start_wd   = start_rd;
                last_wd    = last_rd;
                j_next     = j_reg + CW'(1);
                state_next = S_DN_RD;
            end

            S_UP_RD:
            begin
                if (j_reg > lo_reg)
                begin
                    raddr      = AW'(j_reg - CW'(1));
                    state_next = S_UP_WR;
                end
                else
                begin
                    we_start   = 1'b1;
                    we_last    = 1'b1;
                    waddr      = lo_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_RB_RD;
                end
            end

            S_UP_WR:
            begin
                we_start   = 1'b1;
                we_last    = 1'b1;
                waddr      = j_reg[AW-1:0];
                start_wd   = start_rd;
                last_wd    = last_rd;
                j_next     = j_reg - CW'(1);
                state_next = S_UP_RD;
            end

            S_RB_RD:
            begin
                if (j_reg < count_reg)
                begin
                    raddr      = j_reg[AW-1:0];
                    state_next = S_RB_WR;
                end
                else
                begin
                    mcount_next     = acc_reg;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_RB_WR:
            begin
                we_off     = 1'b1;
                waddr      = j_reg[AW-1:0];
                acc_next   = acc_reg + {1'b0, last_rd - start_rd} + (KW+1)'(1);
                j_next     = j_reg + CW'(1);
                state_next = S_RB_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_wide[31:0];
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        j_reg          <= j_next;
        acc_reg        <= acc_next;
        left_reg       <= left_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mcount_reg    <= mcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/interval_index_set_rank_select.sv @@
// top level: request queue feeding the run table engine
// lookups run a binary search loop over the run table, one ram read and one compare per step;
// inserts may shift runs in the table and then rebuild the offsets of all runs
// one request is worked at a time; two more wait in the front queue, one result in the output
// reset clears run and member counts at once; table rams need no clearing pass
module interval_index_set_rank_select
    import iisrs_pkg::*;
#(
    parameter int MAX_RUNS   = 64,
    parameter int INDEX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  command,
    input  logic [31:0] key,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] value,
    output logic [1:0]  status
);

    logic                  q_valid;
    logic                  q_take;
    op_t                   q_op;
    logic [INDEX_BITS-1:0] q_key;

    iisrs_front #(.KW(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .command(command), .key(key),
        .q_valid(q_valid), .q_take(q_take), .q_op(q_op), .q_key(q_key)
    );

    iisrs_back #(.MAX_RUNS(MAX_RUNS), .KW(INDEX_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_take(q_take), .q_op(q_op), .q_key(q_key),
        .empty(empty), .pop(pop), .value(value), .status(status)
    );

endmodule

@@ rtl/core/iisrs_checker.sv @@
// port level checks for the interval index set block, bound to the top level
module iisrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] value,
    input logic [1:0]  status
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> status != 2'd3)
        else $error("status code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != 2'd0) |-> value == 32'd0)
        else $error("failed request carries nonzero value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value) && $stable(status)))
        else $error("waiting result changed");

endmodule

bind interval_index_set_rank_select iisrs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .value(value), .status(status)
);
